// File: sv/jecf_pkg.sv
`timescale 1ns / 1ps
// Package for the joystick event change filter: field widths, register
// indexes, event kind codes, reset values and the result item type. No dependencies.
package jecf_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;

  // Field widths.
  localparam int KIND_W  = 2;
  localparam int NUM_W   = 8;
  localparam int VAL_W   = 16;
  localparam int TIME_W  = 32;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int SUM_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Stream payload widths; the tdata widths are padded to whole bytes.
  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 56;
  localparam int M_TUSER_W = 1;

  // Event kinds.
  localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd1;
  localparam logic [KIND_W-1:0] KIND_AXIS   = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH      = 3'd5;

  // Register reset values.
  localparam logic [VAL_W-1:0]        NOISE_THRESHOLD_RST = 16'd900;
  localparam logic signed [VAL_W-1:0] CLAMP_LOW_RST       = -16'sd32767;
  localparam logic signed [VAL_W-1:0] CLAMP_HIGH_RST      = 16'sd32767;

  typedef struct packed {
    logic [TIME_W-1:0]       timestamp;
    logic signed [VAL_W-1:0] element_value;
    logic                    is_switch;
    logic [IDX_W-1:0]        element_index;
  } out_item_t;

endpackage

// File: sv/joystick_event_change_filter.sv
`timescale 1ns / 1ps
// Top level of the joystick event change filter: per-element value store with
// change filtering. Depends on jecf_pkg and jecf_ram.
//
// Usage:
//   Events enter on the s_ stream channel (s_tuser carries kind and initial flag,
//   s_tdata carries element number, raw value and time stamp). Change results leave
//   on the m_ stream channel. Registers are written through the cfg_ channel, which
//   is always ready; write them only while no event is in flight.
//   The block takes one transaction per clock cycle while s_tready is high. The
//   element store is read at the edge that accepts an event, and the compare,
//   clamp and write back take the next cycle, at the end of which the result
//   is written into the output queue. An event that hits the slot written by
//   the event just before it gets the new value through a forwarding register,
//   since the store reads old data. Results wait in a four-entry output queue,
//   so a stalled receiver does not stop input until the queue is nearly full;
//   s_tready then drops until room returns. After reset the store is cleared
//   one entry per cycle, from entry 0 up to the last entry; s_tready stays low
//   during that pass while register writes are still taken. Registers return
//   to their reset values at reset.
module joystick_event_change_filter
  import jecf_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Event input.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,  // element_number[7:0], raw_value[23:8],
                                          // event_time[55:24]
  input  logic [S_TUSER_W-1:0]  s_tuser,  // event_kind[1:0], initial_flag[2]
  // Result output.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,  // element_index[5:0], element_value[21:6],
                                          // timestamp[53:22], zero[55:54]
  output logic [M_TUSER_W-1:0]  m_tuser,  // is_switch[0]
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(MAX_ELEMENTS);
  localparam logic [SUM_W-1:0]  MAX_SUM   = SUM_W'(MAX_ELEMENTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_ELEMENTS - 1);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Configuration registers.
  logic                    report_enable;
  logic [CNT_W-1:0]        axis_count;
  logic [CNT_W-1:0]        button_count;
  logic [VAL_W-1:0]        noise_threshold;
  logic signed [VAL_W-1:0] clamp_low;
  logic signed [VAL_W-1:0] clamp_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_enable   <= 1'b0;
      axis_count      <= '0;
      button_count    <= '0;
      noise_threshold <= NOISE_THRESHOLD_RST;
      clamp_low       <= CLAMP_LOW_RST;
      clamp_high      <= CLAMP_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REPORT_ENABLE:   report_enable   <= cfg_data[0];
        REG_AXIS_COUNT:      axis_count      <= cfg_data[CNT_W-1:0];
        REG_BUTTON_COUNT:    button_count    <= cfg_data[CNT_W-1:0];
        REG_NOISE_THRESHOLD: noise_threshold <= cfg_data;
        REG_CLAMP_LOW:       clamp_low       <= cfg_data;
        REG_CLAMP_HIGH:      clamp_high      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [KIND_W-1:0]       in_kind;
  logic                    in_initial;
  logic [NUM_W-1:0]        in_num;
  logic signed [VAL_W-1:0] in_raw;
  logic [TIME_W-1:0]       in_time;

  assign in_kind    = s_tuser[1:0];
  assign in_initial = s_tuser[2];
  assign in_num     = s_tdata[7:0];
  assign in_raw     = s_tdata[23:8];
  assign in_time    = s_tdata[55:24];

  // Clearing pass after reset.
  logic              clearing;
  logic [SLOT_W-1:0] clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == LAST_SLOT) begin
        clearing <= 1'b0;
      end
    end
  end

  // Stage 0: slot computation and range check, store read issued.
  logic             s_accept;
  logic [SUM_W-1:0] slot_sum;
  logic             in_range;
  logic             in_button;

  assign s_accept  = s_tvalid && s_tready;
  assign in_button = (in_kind == KIND_BUTTON);
  assign slot_sum  = in_button ? (SUM_W'(axis_count) + SUM_W'(in_num)) : SUM_W'(in_num);

  always_comb begin
    case (in_kind)
      KIND_BUTTON: in_range = (SUM_W'(in_num) < SUM_W'(button_count)) && (slot_sum < MAX_SUM);
      KIND_AXIS:   in_range = (SUM_W'(in_num) < SUM_W'(axis_count)) && (slot_sum < MAX_SUM);
      default:     in_range = 1'b0;
    endcase
  end

  // Stage 1 registers.
  logic                    s1_valid;
  logic                    s1_live;
  logic                    s1_button;
  logic                    s1_initial;
  logic [SLOT_W-1:0]       s1_slot;
  logic [IDX_W-1:0]        s1_index;
  logic signed [VAL_W-1:0] s1_raw;
  logic [TIME_W-1:0]       s1_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_live  <= 1'b0;
    end else begin
      s1_valid <= s_accept;
      s1_live  <= s_accept && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_button  <= in_button;
      s1_initial <= in_initial;
      s1_slot    <= slot_sum[SLOT_W-1:0];
      s1_index   <= slot_sum[IDX_W-1:0];
      s1_raw     <= in_raw;
      s1_time    <= in_time;
    end
  end

  // Element store and forwarding of a write that collides with a read.
  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  logic [VAL_W-1:0]        ram_wdata;
  logic [VAL_W-1:0]        ram_rdata;
  logic                    upd_we;
  logic signed [VAL_W-1:0] upd_value;
  logic                    fwd_hit;
  logic [VAL_W-1:0]        fwd_data;

  assign ram_we    = clearing || upd_we;
  assign ram_waddr = clearing ? clear_addr : s1_slot;
  assign ram_wdata = clearing ? '0 : upd_value;

  jecf_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(slot_sum[SLOT_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= s_accept && upd_we && (s1_slot == slot_sum[SLOT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= upd_value;
  end

  // Stage 1: compare, clamp and write back.
  logic signed [VAL_W-1:0] stored;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W:0]          mag;
  logic                    moved;
  logic signed [VAL_W-1:0] clamped;
  logic                    push;

  assign stored = fwd_hit ? fwd_data : ram_rdata;
  assign diff   = {s1_raw[VAL_W-1], s1_raw} - {stored[VAL_W-1], stored};
  assign mag    = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
  assign moved  = mag >= {1'b0, noise_threshold};

  always_comb begin
    if (s1_raw < clamp_low) begin
      clamped = clamp_low;
    end else if (s1_raw > clamp_high) begin
      clamped = clamp_high;
    end else begin
      clamped = s1_raw;
    end
  end

  assign upd_we    = s1_live && (s1_button || moved);
  assign upd_value = s1_button ? VAL_W'(s1_raw != '0) : clamped;
  assign push      = upd_we && !s1_initial && report_enable;

  // Output queue.
  out_item_t         queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_count;
  logic              pop;
  out_item_t         head;
  out_item_t         new_item;

  assign pop  = m_tvalid && m_tready;
  assign head = queue[rd_ptr];

  assign new_item.timestamp     = s1_time;
  assign new_item.element_value = upd_value;
  assign new_item.is_switch     = s1_button;
  assign new_item.element_index = s1_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      q_count <= q_count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_item;
    end
  end

  // Room is kept for the event in stage 1 and the one being accepted.
  assign s_tready = !clearing && ((q_count + QCNT_W'(s1_valid)) <= QCNT_W'(QDEPTH - 1));

  assign m_tvalid = (q_count != '0);
  assign m_tdata  = {2'b00, head.timestamp, head.element_value, head.element_index};
  assign m_tuser  = head.is_switch;

  // Assertions.
  a_no_accept_while_clearing: assert property (@(posedge clk)
    clearing |-> !s_accept)
    else $error("event accepted during store clearing");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (q_count == QCNT_W'(QDEPTH))))
    else $error("output queue overflow");

  a_forward_on_collision: assert property (@(posedge clk) disable iff (rst)
    (s_accept && upd_we && (s1_slot == slot_sum[SLOT_W-1:0])) |=> fwd_hit)
    else $error("store collision not forwarded");

  a_clear_complete: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> ($past(clear_addr) == LAST_SLOT))
    else $error("clearing pass ended early");

endmodule

// File: sv/jecf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read port.
// Self-contained; no package dependency.
module jecf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: verif/jecf_checker.sv
`timescale 1ns / 1ps
// Result checker for the joystick event change filter: tracks register writes,
// predicts every change result from the accepted events and checks the result stream.
// Depends on jecf_pkg.
module jecf_checker
  import jecf_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic [S_TUSER_W-1:0]  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,
  input  logic [M_TUSER_W-1:0]  m_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    error_count,
  output int                    pending,
  output int                    events_taken,
  output int                    results_checked
);

  bit                      report_on;
  int                      n_axes;
  int                      n_buttons;
  int                      noise;
  int                      clamp_lo;
  int                      clamp_hi;
  logic signed [VAL_W-1:0] slot_values [MAX_ELEMENTS];
  out_item_t               expected_changes [$];
  int                      fails = 0;
  int                      n_events = 0;
  int                      n_results = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic clear_filter();
    report_on = 1'b0;
    n_axes = 0;
    n_buttons = 0;
    noise = NOISE_THRESHOLD_RST;
    clamp_lo = CLAMP_LOW_RST;
    clamp_hi = CLAMP_HIGH_RST;
    for (int k = 0; k < MAX_ELEMENTS; k++) slot_values[k] = '0;
    expected_changes.delete();
  endtask

  // Updates the element store for one event and returns 1 when a change result
  // is due.
  function automatic bit filter_event(input logic [KIND_W-1:0] kind,
                                      input logic init_evt,
                                      input logic [NUM_W-1:0] num,
                                      input logic signed [VAL_W-1:0] raw,
                                      input logic [TIME_W-1:0] stamp,
                                      output out_item_t change);
    int slot;
    int diff;
    int v;
    bit sw;
    change = '0;
    if (kind == KIND_BUTTON) begin
      slot = n_axes + int'(num);
      if (int'(num) >= n_buttons || slot >= MAX_ELEMENTS) return 1'b0;
      slot_values[slot] = (raw != 0) ? 16'sd1 : 16'sd0;
      sw = 1'b1;
    end else if (kind == KIND_AXIS) begin
      slot = int'(num);
      if (slot >= n_axes || slot >= MAX_ELEMENTS) return 1'b0;
      diff = int'(raw) - int'(slot_values[slot]);
      if (diff < 0) diff = -diff;
      if (diff < noise) return 1'b0;
      v = raw;
      if (v < clamp_lo) v = clamp_lo;
      else if (v > clamp_hi) v = clamp_hi;
      slot_values[slot] = v[VAL_W-1:0];
      sw = 1'b0;
    end else begin
      return 1'b0;
    end
    if (init_evt || !report_on) return 1'b0;
    change.element_index = slot[IDX_W-1:0];
    change.is_switch = sw;
    change.element_value = slot_values[slot];
    change.timestamp = stamp;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (rst) begin
      clear_filter();
    end else begin
      if (m_tvalid && m_tready) begin
        got.element_index = m_tdata[IDX_W-1:0];
        got.element_value = m_tdata[IDX_W+VAL_W-1:IDX_W];
        got.timestamp = m_tdata[IDX_W+VAL_W+TIME_W-1:IDX_W+VAL_W];
        got.is_switch = m_tuser[0];
        n_results++;
        if (expected_changes.size() == 0) begin
          report_mismatch($sformatf("unexpected result: slot %0d value %0d time %0h",
                                    got.element_index, got.element_value, got.timestamp));
        end else begin
          want = expected_changes.pop_front();
          if (got.element_index != want.element_index)
            report_mismatch($sformatf("element_index: expected %0d, got %0d",
                                      want.element_index, got.element_index));
          if (got.is_switch != want.is_switch)
            report_mismatch($sformatf("is_switch at slot %0d: expected %0d, got %0d",
                                      want.element_index, want.is_switch, got.is_switch));
          if (got.element_value != want.element_value)
            report_mismatch($sformatf("element_value at slot %0d: expected %0d, got %0d",
                                      want.element_index, want.element_value,
                                      got.element_value));
          if (got.timestamp != want.timestamp)
            report_mismatch($sformatf("timestamp at slot %0d: expected %0h, got %0h",
                                      want.element_index, want.timestamp, got.timestamp));
          if (m_tdata[M_TDATA_W-1:IDX_W+VAL_W+TIME_W] != '0)
            report_mismatch($sformatf("tdata padding not zero: %0h",
                                      m_tdata[M_TDATA_W-1:IDX_W+VAL_W+TIME_W]));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REPORT_ENABLE:   report_on = cfg_data[0];
          REG_AXIS_COUNT:      n_axes = cfg_data[CNT_W-1:0];
          REG_BUTTON_COUNT:    n_buttons = cfg_data[CNT_W-1:0];
          REG_NOISE_THRESHOLD: noise = cfg_data;
          REG_CLAMP_LOW:       clamp_lo = $signed(cfg_data);
          REG_CLAMP_HIGH:      clamp_hi = $signed(cfg_data);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        n_events++;
        if (filter_event(s_tuser[KIND_W-1:0], s_tuser[KIND_W], s_tdata[NUM_W-1:0],
                         s_tdata[NUM_W+VAL_W-1:NUM_W],
                         s_tdata[NUM_W+VAL_W+TIME_W-1:NUM_W+VAL_W], want))
          expected_changes.push_back(want);
      end
    end
    pending <= expected_changes.size();
    error_count <= fails;
    events_taken <= n_events;
    results_checked <= n_results;
  end

endmodule

// File: verif/tb_joystick_event_change_filter.sv
`timescale 1ns / 1ps
// Testbench top for the joystick event change filter: clock, reset, register
// setups, event stimulus and the verdict. Depends on jecf_pkg, jecf_checker and
// the joystick_event_change_filter RTL.
module tb_joystick_event_change_filter;
  import jecf_pkg::*;

  // A run with no transaction for this many cycles is considered hung. The
  // worst honest silence is the store clearing pass after reset.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES = 10;
  localparam int EVENTS_PER_PHASE = 110;

  // Event kinds the block must ignore, and a register index that maps to nothing.
  localparam logic [KIND_W-1:0]    KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0]    KIND_OTHER = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int pending;
  int events_taken;
  int results_checked;

  // Sender and receiver pacing state.
  int         burst_left = 0;
  logic [7:0] stall_phase = '0;
  int         idle_cycles = 0;

  // Current register setup as written by this testbench; it only steers the
  // stimulus toward interesting element numbers and raw values.
  int cur_axes = 0;
  int cur_buttons = 0;
  int cur_noise = 900;
  int setups = 0;
  int last_axis_raw [256];

  always #5 clk = ~clk;

  joystick_event_change_filter uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  jecf_checker change_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .error_count     (mismatches),
    .pending         (pending),
    .events_taken    (events_taken),
    .results_checked (results_checked)
  );

  // The receiver walks through four stall styles, picked by stall_phase[7:6]:
  // always ready, ready only when stall_phase[1:0] is zero, coin flips, and long
  // stalls that fill the output queue and push back on the event input.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    case (stall_phase[7:6])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= (stall_phase[1:0] == 2'd0);
      2'd2: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= (stall_phase[3:0] < 4'd3);
    endcase
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results still expected",
               WATCHDOG_LIMIT, pending);
      $display("tb_joystick_event_change_filter NOT OK");
      $finish;
    end
  end

  // One register write transaction. The caller lowers cfg_valid once its
  // sequence of writes is done, so valid never drops and rises in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all six registers. The narrow registers get random upper bits,
  // which the block has to ignore.
  task automatic set_config(input bit re, input int ac, input int bc, input int nz,
                            input int lo, input int hi);
    write_reg(REG_REPORT_ENABLE, {15'($urandom()), re});
    write_reg(REG_AXIS_COUNT, {9'($urandom()), 7'(ac)});
    write_reg(REG_BUTTON_COUNT, {9'($urandom()), 7'(bc)});
    write_reg(REG_NOISE_THRESHOLD, 16'(nz));
    write_reg(REG_CLAMP_LOW, 16'(lo));
    write_reg(REG_CLAMP_HIGH, 16'(hi));
    cfg_valid <= 1'b0;
    cur_axes = ac;
    cur_buttons = bc;
    cur_noise = nz;
    setups++;
  endtask

  // Offers one event and returns once it has been taken. The sender works in
  // bursts; between bursts it may drop tvalid for a random number of cycles.
  task automatic send_event(input logic [KIND_W-1:0] kind, input logic init_evt,
                            input logic [NUM_W-1:0] num,
                            input logic signed [VAL_W-1:0] raw,
                            input logic [TIME_W-1:0] stamp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {stamp, raw, num};
    s_tuser <= {init_evt, kind};
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  // Random event, mostly well formed for the current setup: element numbers
  // inside the axis or button range and raw values close to the last value
  // sent for that axis, so that the noise compare sees both sides of the
  // threshold. The rest are ignored kinds and numbers anywhere in 0..255.
  task automatic send_random_event();
    int                pick;
    int                raw;
    logic [KIND_W-1:0] kind;
    logic [NUM_W-1:0]  num;
    logic              init_evt;
    pick = $urandom_range(0, 99);
    init_evt = ($urandom_range(0, 9) == 0);
    if (pick < 4) begin
      kind = pick[0] ? KIND_OTHER : KIND_NONE;
      num = 8'($urandom());
    end else if (pick < 14) begin
      kind = pick[0] ? KIND_AXIS : KIND_BUTTON;
      num = 8'($urandom());
    end else if (pick < 60 && cur_axes > 0) begin
      kind = KIND_AXIS;
      num = 8'($urandom_range(0, cur_axes - 1));
    end else if (cur_buttons > 0) begin
      kind = KIND_BUTTON;
      num = 8'($urandom_range(0, cur_buttons - 1));
    end else begin
      kind = KIND_AXIS;
      num = 8'($urandom_range(0, 63));
    end
    case ($urandom_range(0, 9))
      0: raw = $urandom_range(0, 1) ? 32767 : -32768;
      1, 2: raw = $signed(16'($urandom()));
      default: raw = last_axis_raw[num] + int'($urandom_range(0, 2 * cur_noise + 2))
                     - cur_noise - 1;
    endcase
    if (raw > 32767) raw = 32767;
    if (raw < -32768) raw = -32768;
    if (kind == KIND_BUTTON && $urandom_range(0, 2) == 0) raw = 0;
    if (kind == KIND_AXIS) last_axis_raw[num] = raw;
    send_event(kind, init_evt, num, 16'(raw), 32'($urandom()));
  endtask

  // Stops offering events and waits until every expected result has been
  // taken. An event without a result may still be inside the two-stage
  // pipeline then, so the task waits longer before the next register write.
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int lo;
    int hi;
    int tmp;
    foreach (last_axis_raw[k]) last_axis_raw[k] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Eight axes in slots 0..7, twelve buttons in slots 8..19,
    // axis values clamped to +/-20000, default noise threshold.
    set_config(1'b1, 8, 12, 900, -20000, 20000);
    // Unknown kinds are ignored, with and without the initial flag.
    send_event(KIND_NONE, 1'b0, 8'd0, 16'sd100, 32'd0);
    send_event(KIND_OTHER, 1'b1, 8'hFF, -16'sd1, 32'hFFFF_FFFF);
    // Full-scale axis values clamp to both limits.
    send_event(KIND_AXIS, 1'b0, 8'd0, 16'sd32767, 32'hFFFF_FFFF);
    send_event(KIND_AXIS, 1'b0, 8'd0, -16'sd32768, 32'd0);
    // One below the threshold is noise; exactly the threshold is movement.
    send_event(KIND_AXIS, 1'b0, 8'd0, -16'sd19101, 32'h0000_0010);
    send_event(KIND_AXIS, 1'b0, 8'd0, -16'sd19100, 32'h0000_0011);
    send_event(KIND_AXIS, 1'b0, 8'd7, 16'sd900, 32'h8000_0000);
    send_event(KIND_AXIS, 1'b0, 8'd7, 16'sd1799, 32'h8000_0001);
    // Axis numbers past the axis count, including the largest number.
    send_event(KIND_AXIS, 1'b0, 8'd8, 16'sd5000, 32'h0000_0020);
    send_event(KIND_AXIS, 1'b0, 8'd255, 16'sd5000, 32'h0000_0021);
    // Buttons: any nonzero value is pressed; first and last button, then a
    // release of the same button right behind its press.
    send_event(KIND_BUTTON, 1'b0, 8'd0, -16'sd1, 32'h1234_5678);
    send_event(KIND_BUTTON, 1'b0, 8'd11, -16'sd32768, 32'h1234_5679);
    send_event(KIND_BUTTON, 1'b0, 8'd11, 16'sd0, 32'h1234_567A);
    // Button numbers past the button count.
    send_event(KIND_BUTTON, 1'b0, 8'd12, 16'sd1, 32'h0000_0030);
    send_event(KIND_BUTTON, 1'b0, 8'd255, 16'sd1, 32'h0000_0031);
    // An initial-state event updates the store silently; the next small move
    // is measured against that stored value.
    send_event(KIND_AXIS, 1'b1, 8'd3, 16'sd10000, 32'h0000_0040);
    send_event(KIND_AXIS, 1'b0, 8'd3, 16'sd10500, 32'h0000_0041);
    send_event(KIND_AXIS, 1'b0, 8'd3, 16'sd12000, 32'h0000_0042);
    send_event(KIND_BUTTON, 1'b1, 8'd3, 16'sd1, 32'h0000_0043);
    // Two changes on one axis in a row exercise the write-back forwarding.
    send_event(KIND_AXIS, 1'b0, 8'd5, 16'sd5000, 32'h0000_0050);
    send_event(KIND_AXIS, 1'b0, 8'd5, 16'sd4000, 32'h0000_0051);
    drain();

    // Random part, one register setup per phase. The first phases pin the
    // extremes: noise 0 and 65535, full clamp range, an inverted clamp,
    // reporting off, counts of 0, 64 and 127, and buttons that run past the
    // last slot. The last phases draw everything at random.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_SPARE, 16'hFFFF);
          set_config(1'b1, 16, 16, 900, -32767, 32767);
        end
        1: set_config(1'b1, 64, 0, 0, -32768, 32767);
        2: set_config(1'b1, 0, 64, 65535, -32768, 32767);
        3: set_config(1'b1, 32, 32, $urandom_range(0, 1500), 1000, -1000);
        4: set_config(1'b0, 20, 20, 500, -32767, 32767);
        5: set_config(1'b1, 127, 127, 200, -5000, 5000);
        6: set_config(1'b1, 60, 10, 300, -30000, 30000);
        default: begin
          lo = int'($urandom_range(0, 65535)) - 32768;
          hi = int'($urandom_range(0, 65535)) - 32768;
          if (lo > hi && $urandom_range(0, 3) != 0) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
          end
          set_config($urandom_range(0, 5) != 0, $urandom_range(1, 64),
                     $urandom_range(1, 64),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 2000),
                     lo, hi);
        end
      endcase
      repeat (EVENTS_PER_PHASE) send_random_event();
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Run covered %0d events over %0d register setups; %0d results checked.",
             events_taken, setups, results_checked);
    $display("Setups spanned reporting off, inverted clamp, noise 0 and 65535, %s",
             "and axis and button counts of 0, 64 and 127.");
    if (mismatches == 0) begin
      $display("tb_joystick_event_change_filter OK");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("tb_joystick_event_change_filter NOT OK");
    end
    $finish;
  end

endmodule
